[hdl/ffts_pkg.sv]
// Package: shared constants, codes and controller/datapath interface types for the fragmenter.
`timescale 1ns / 1ps

package ffts_pkg;

    localparam int SIZE_BITS   = 24;
    localparam int TAG_BITS    = 8;
    localparam int FNUM_BITS   = 8;
    localparam int PART_BITS   = 16;
    localparam int MAXP_BITS   = 16;
    localparam int KIND_BITS   = 3;
    localparam int PEND_BITS   = 2;
    localparam int OFFSET_BITS = SIZE_BITS + MAXP_BITS;

    localparam int BUF_BYTES   = 1500;
    localparam int HDR_BYTES   = 10;
    localparam logic [MAXP_BITS-1:0] MAX_PAYLOAD_RESET = MAXP_BITS'(BUF_BYTES - HDR_BYTES);
    localparam logic [FNUM_BITS-1:0] FRAME_INDEX_MAX   = FNUM_BITS'(8'hff);
    localparam logic [FNUM_BITS-1:0] FRAME_INDEX_FIRST = FNUM_BITS'(1);

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = MAXP_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TX_ENABLE   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD = 1'b1;

    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 120;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SUBMIT    = 3'd0,
        KIND_SEND_DONE = 3'd1,
        KIND_PEER_MSG  = 3'd2,
        KIND_PEER_LOST = 3'd3,
        KIND_CLEAR     = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVT   = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_ISSUE = 5'b01000,
        ST_LOAD  = 5'b10000
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic evt;
        logic mul;
        logic issue;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic do_issue;
        logic out_free;
    } dp_status_t;

    function automatic logic [FNUM_BITS-1:0] next_frame_index(input logic [FNUM_BITS-1:0] fn);
        logic [FNUM_BITS-1:0] res;
        if (fn == FRAME_INDEX_MAX)
            res = FRAME_INDEX_FIRST;
        else
            res = fn + FNUM_BITS'(1);
        return res;
    endfunction

endpackage

[hdl/frame_fragmenter_two_slot_core.sv]
// Top level of the two-slot frame fragmenter: controller and datapath.
`timescale 1ns / 1ps

// Each input beat yields exactly one result beat. A beat that issues no part goes through
// accept, event update and result load; a beat that issues a part also goes through an
// offset multiply and a part issue, as the part offset goes through a registered multiply and
// the part is issued in the cycle after it. The sequence is set by the controller, which
// handles one beat at a time. The result register is separate from the input side: the next
// input beat is taken while a result still waits, and only the result load waits for m_tready.
module frame_fragmenter_two_slot_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // frame_bytes [23:0], frame_handle [31:24], video_on [32], zeros above
    input  logic [ffts_pkg::IN_TDATA_BITS-1:0]     s_tdata,
    // kind [2:0]
    input  logic [ffts_pkg::KIND_BITS-1:0]         s_tuser,
    input  logic                                   cfg_we,
    input  logic [ffts_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ffts_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // hdr_frame [7:0], hdr_part [23:8], hdr_part_max [39:24], total_size [63:40],
    // payload_offset [87:64], payload_length [103:88], buffer_tag [111:104],
    // pending_count [113:112], peer_up [114], zeros above
    output logic [ffts_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
    // pkt_valid [0]
    output logic                                   m_tuser,
    // last_part
    output logic                                   m_tlast
);
    import ffts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ffts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffts_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[hdl/ffts_ctrl.sv]
// Controller: sequences accept, event update, offset multiply, part issue and result load.
`timescale 1ns / 1ps

module ffts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ffts_pkg::dp_status_t status,
    output ffts_pkg::dp_cmd_t    cmd
);
    import ffts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
                if (s_tvalid)
                    state_next = ST_EVT;
            end
            ST_EVT:
            begin
                cmd.evt = 1'b1;
                if (status.do_issue)
                    state_next = ST_MUL;
                else
                    state_next = ST_LOAD;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/ffts_dp.sv]
// Datapath: frame slots, peer and send state, part arithmetic, settings and the result register.
`timescale 1ns / 1ps

module ffts_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ffts_pkg::dp_cmd_t                      cmd,
    output ffts_pkg::dp_status_t                   status,
    input  logic [ffts_pkg::IN_TDATA_BITS-1:0]     s_tdata,
    input  logic [ffts_pkg::KIND_BITS-1:0]         s_tuser,
    input  logic                                   cfg_we,
    input  logic [ffts_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ffts_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [ffts_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import ffts_pkg::*;

    // Latched input beat.
    logic [KIND_BITS-1:0] kind_reg;
    logic [SIZE_BITS-1:0] in_size_reg;
    logic [TAG_BITS-1:0]  in_tag_reg;
    logic                 in_video_reg;

    // Settings.
    logic                 tx_en_reg;
    logic [MAXP_BITS-1:0] max_pay_reg;

    // Block state.
    logic [1:0]           slot_valid_reg, slot_valid_next;
    logic [SIZE_BITS-1:0] slot_size_reg [2];
    logic [SIZE_BITS-1:0] slot_size_next [2];
    logic [TAG_BITS-1:0]  slot_tag_reg [2];
    logic [TAG_BITS-1:0]  slot_tag_next [2];
    logic                 busy_reg, busy_next;
    logic                 peer_reg, peer_next;
    logic [SIZE_BITS-1:0] pc_reg, pc_next;
    logic [FNUM_BITS-1:0] fn_reg, fn_next;

    logic [OFFSET_BITS-1:0] offset_reg;

    // Part descriptor of the current item.
    logic                 pkt_valid_reg, pkt_valid_next;
    logic [FNUM_BITS-1:0] pkt_fn_reg, pkt_fn_next;
    logic [PART_BITS-1:0] pkt_part_reg, pkt_part_next;
    logic [MAXP_BITS-1:0] pkt_maxp_reg, pkt_maxp_next;
    logic [SIZE_BITS-1:0] pkt_total_reg, pkt_total_next;
    logic [SIZE_BITS-1:0] pkt_off_reg, pkt_off_next;
    logic [MAXP_BITS-1:0] pkt_len_reg, pkt_len_next;
    logic [TAG_BITS-1:0]  pkt_tag_reg, pkt_tag_next;
    logic                 pkt_last_reg, pkt_last_next;

    // Result register.
    logic                      out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;
    logic                      out_user_reg;
    logic                      out_last_reg;

    // Event evaluation.
    logic [1:0]           e_v;
    logic [SIZE_BITS-1:0] e_s [2];
    logic [TAG_BITS-1:0]  e_t [2];
    logic                 e_busy;
    logic                 e_peer;
    logic [SIZE_BITS-1:0] e_pc;
    logic [FNUM_BITS-1:0] e_fn;
    logic                 e_clr;
    logic                 e_try;
    logic                 e_issue;
    logic                 e_slot;

    // Part arithmetic.
    logic [MAXP_BITS-1:0]   mp;
    logic [OFFSET_BITS-1:0] prod;
    logic [SIZE_BITS-1:0]   remaining;
    logic [MAXP_BITS-1:0]   part_len;
    logic                   part_last;
    logic [SIZE_BITS-1:0]   part_off;
    logic [PEND_BITS-1:0]   pending;

    assign mp   = (max_pay_reg == '0) ? MAXP_BITS'(1) : max_pay_reg;
    assign prod = OFFSET_BITS'(pc_reg) * OFFSET_BITS'(mp);

    always_comb
    begin
        e_v     = slot_valid_reg;
        e_s     = slot_size_reg;
        e_t     = slot_tag_reg;
        e_busy  = busy_reg;
        e_peer  = peer_reg;
        e_pc    = pc_reg;
        e_fn    = fn_reg;
        e_clr   = 1'b0;
        e_try   = 1'b0;
        e_slot  = 1'b0;
        case (kind_reg)
            KIND_SUBMIT:
            begin
                e_try  = 1'b1;
                e_slot = slot_valid_reg[0] && busy_reg;
                if (in_size_reg == '0)
                begin
                    e_v[e_slot] = 1'b0;
                    e_s[e_slot] = '0;
                    e_t[e_slot] = '0;
                end
                else
                begin
                    e_v[e_slot] = 1'b1;
                    e_s[e_slot] = in_size_reg;
                    e_t[e_slot] = in_tag_reg;
                end
            end
            KIND_SEND_DONE:
            begin
                e_try  = 1'b1;
                e_busy = 1'b0;
            end
            KIND_PEER_MSG:
            begin
                e_try  = 1'b1;
                e_peer = in_video_reg;
                e_clr  = !in_video_reg;
            end
            KIND_PEER_LOST:
            begin
                e_peer = 1'b0;
                e_clr  = 1'b1;
            end
            KIND_CLEAR:
            begin
                e_clr = 1'b1;
            end
            default:
            begin
                e_clr = 1'b0;
            end
        endcase
        // An attempt to send while the peer is gone drops the queued frames.
        if (e_try && !e_busy && !e_peer)
            e_clr = 1'b1;
        if (e_clr)
        begin
            e_v[1] = 1'b0;
            e_s[1] = '0;
            e_t[1] = '0;
            if (e_v[0] && !e_busy)
            begin
                e_v[0] = 1'b0;
                e_s[0] = '0;
                e_t[0] = '0;
                e_fn   = next_frame_index(e_fn);
            end
            if (!e_busy && !tx_en_reg)
                e_pc = '0;
        end
        if (e_try && !e_busy && !e_v[0] && !tx_en_reg)
            e_pc = '0;
        e_issue = e_try && !e_busy && e_peer && tx_en_reg && e_v[0];
    end

    always_comb
    begin
        if ({{MAXP_BITS{1'b0}}, slot_size_reg[0]} > offset_reg)
            remaining = slot_size_reg[0] - offset_reg[SIZE_BITS-1:0];
        else
            remaining = '0;
        if (remaining < SIZE_BITS'(mp))
            part_len = remaining[MAXP_BITS-1:0];
        else
            part_len = mp;
        part_last = remaining <= SIZE_BITS'(mp);
        if (offset_reg[OFFSET_BITS-1:SIZE_BITS] != '0)
            part_off = '1;
        else
            part_off = offset_reg[SIZE_BITS-1:0];
    end

    always_comb
    begin
        if (!slot_valid_reg[0])
            pending = PEND_BITS'(0);
        else if (!slot_valid_reg[1])
            pending = busy_reg ? PEND_BITS'(0) : PEND_BITS'(1);
        else
            pending = busy_reg ? PEND_BITS'(1) : PEND_BITS'(2);
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_size_next  = slot_size_reg;
        slot_tag_next   = slot_tag_reg;
        busy_next       = busy_reg;
        peer_next       = peer_reg;
        pc_next         = pc_reg;
        fn_next         = fn_reg;
        pkt_valid_next  = pkt_valid_reg;
        pkt_fn_next     = pkt_fn_reg;
        pkt_part_next   = pkt_part_reg;
        pkt_maxp_next   = pkt_maxp_reg;
        pkt_total_next  = pkt_total_reg;
        pkt_off_next    = pkt_off_reg;
        pkt_len_next    = pkt_len_reg;
        pkt_tag_next    = pkt_tag_reg;
        pkt_last_next   = pkt_last_reg;
        if (cmd.evt)
        begin
            slot_valid_next = e_v;
            slot_size_next  = e_s;
            slot_tag_next   = e_t;
            busy_next       = e_busy;
            peer_next       = e_peer;
            pc_next         = e_pc;
            fn_next         = e_fn;
            pkt_valid_next  = 1'b0;
            pkt_fn_next     = '0;
            pkt_part_next   = '0;
            pkt_maxp_next   = '0;
            pkt_total_next  = '0;
            pkt_off_next    = '0;
            pkt_len_next    = '0;
            pkt_tag_next    = '0;
            pkt_last_next   = 1'b0;
        end
        if (cmd.issue)
        begin
            pkt_valid_next = 1'b1;
            pkt_fn_next    = fn_reg;
            pkt_part_next  = pc_reg[PART_BITS-1:0];
            pkt_maxp_next  = mp;
            pkt_total_next = slot_size_reg[0];
            pkt_off_next   = part_off;
            pkt_len_next   = part_len;
            pkt_tag_next   = slot_tag_reg[0];
            pkt_last_next  = part_last;
            busy_next      = 1'b1;
            if (!part_last)
            begin
                pc_next = pc_reg + SIZE_BITS'(1);
            end
            else
            begin
                pc_next            = '0;
                fn_next            = next_frame_index(fn_reg);
                slot_valid_next[0] = slot_valid_reg[1];
                slot_size_next[0]  = slot_size_reg[1];
                slot_tag_next[0]   = slot_tag_reg[1];
                slot_valid_next[1] = 1'b0;
                slot_size_next[1]  = '0;
                slot_tag_next[1]   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            slot_size_reg  <= '{default: '0};
            slot_tag_reg   <= '{default: '0};
            busy_reg       <= 1'b0;
            peer_reg       <= 1'b0;
            pc_reg         <= '0;
            fn_reg         <= FRAME_INDEX_FIRST;
            tx_en_reg      <= 1'b1;
            max_pay_reg    <= MAX_PAYLOAD_RESET;
            pkt_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            slot_size_reg  <= slot_size_next;
            slot_tag_reg   <= slot_tag_next;
            busy_reg       <= busy_next;
            peer_reg       <= peer_next;
            pc_reg         <= pc_next;
            fn_reg         <= fn_next;
            pkt_valid_reg  <= pkt_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TX_ENABLE)
                    tx_en_reg <= cfg_data[0];
                else
                    max_pay_reg <= cfg_data;
            end
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg     <= s_tuser;
            in_size_reg  <= s_tdata[SIZE_BITS-1:0];
            in_tag_reg   <= s_tdata[SIZE_BITS+TAG_BITS-1:SIZE_BITS];
            in_video_reg <= s_tdata[SIZE_BITS+TAG_BITS];
        end
        if (cmd.mul)
            offset_reg <= prod;
        pkt_fn_reg    <= pkt_fn_next;
        pkt_part_reg  <= pkt_part_next;
        pkt_maxp_reg  <= pkt_maxp_next;
        pkt_total_reg <= pkt_total_next;
        pkt_off_reg   <= pkt_off_next;
        pkt_len_reg   <= pkt_len_next;
        pkt_tag_reg   <= pkt_tag_next;
        pkt_last_reg  <= pkt_last_next;
        if (cmd.load)
        begin
            out_data_reg <= {5'b0, peer_reg, pending, pkt_tag_reg, pkt_len_reg, pkt_off_reg,
                             pkt_total_reg, pkt_maxp_reg, pkt_part_reg, pkt_fn_reg};
            out_user_reg <= pkt_valid_reg;
            out_last_reg <= pkt_last_reg;
        end
    end

    assign status.do_issue = e_issue;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
